// ----- sv/wlf_pkg.sv -----
// Package for the weighted line fit block: widths, item and config types,
// back-end state encoding and register indexes.
// No dependencies.
`default_nettype none

package wlf_pkg;

  // Field and accumulator widths
  localparam int XW    = 16;
  localparam int WW    = 16;
  localparam int NW    = 24;
  localparam int SXW   = 40;
  localparam int SXXW  = 56;
  localparam int WXW   = 33;   // w * x product
  localparam int WXXW  = 49;   // w * x * x product
  localparam int QOUTW = 32;

  // Shared sequential multiplier
  localparam int OPW   = 57;   // signed operand
  localparam int MAG   = 56;   // operand magnitude
  localparam int DIG   = 14;   // multiplier digit
  localparam int NDIG  = MAG / DIG;
  localparam int MCW   = $clog2(NDIG);
  localparam int PW    = 112;  // product and numerator width

  // Restoring divider
  localparam int DENW      = 82;
  localparam int QW        = 34;
  localparam int DIV_STEPS = PW;
  localparam int DCW       = $clog2(DIV_STEPS + 1);

  // Item queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  // Register indexes on the config port
  localparam logic REG_PROFILE_MODE = 1'b0;
  localparam logic REG_X_UPPER      = 1'b1;

  typedef struct packed {
    logic                 profile_mode;
    logic signed [XW-1:0] x_upper_bound;
  } wlf_cfg_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [WW-1:0]        w;
    logic                 counted;
    logic                 last;
    logic                 profile;
  } wlf_item_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } back_state_t;

endpackage

`default_nettype wire

// ----- sv/wlf_front.sv -----
// Front end: accepts bins, classifies them as counted or not, and queues them.
// Depends on wlf_pkg.
`default_nettype none

module wlf_front (
  input  logic                      clk,
  input  logic                      rst,
  input  wlf_pkg::wlf_cfg_t         cfg,
  input  logic signed [15:0]        x_value,
  input  logic signed [15:0]        y_mean,
  input  logic [15:0]               weight,
  input  logic                      last,
  input  logic                      in_valid,
  output logic                      in_ready,
  output wlf_pkg::wlf_item_t        q_item,
  output logic                      q_valid,
  input  logic                      q_pop
);
  import wlf_pkg::*;

  wlf_item_t        entries [QUEUE_DEPTH];
  wlf_item_t        new_item;
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;
  logic             push;
  logic             pop;

  // Classify: in profile mode an empty bin takes no part in the run.
  always_comb begin
    new_item.x       = x_value;
    new_item.y       = y_mean;
    new_item.w       = weight;
    new_item.counted = !cfg.profile_mode || (weight != '0);
    new_item.last    = last;
    new_item.profile = cfg.profile_mode;
  end

  assign in_ready = (count != QCW'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = entries[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= new_item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/wlf_mul.sv -----
// Sequential signed multiplier, one 14-bit digit of the second operand a cycle.
// Depends on wlf_pkg.
`default_nettype none

module wlf_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [wlf_pkg::OPW-1:0] a,
  input  logic signed [wlf_pkg::OPW-1:0] b,
  output logic                          done,
  output logic signed [wlf_pkg::PW-1:0] prod
);
  import wlf_pkg::*;

  logic                 busy;
  logic                 fix;
  logic [MCW-1:0]       cnt;
  logic [MAG-1:0]       mag_a;
  logic [MAG-1:0]       mag_b;
  logic                 neg;
  logic [PW-1:0]        acc;
  logic signed [OPW-1:0] abs_a;
  logic signed [OPW-1:0] abs_b;
  logic [MAG+DIG-1:0]   partial;

  assign abs_a   = a[OPW-1] ? -a : a;
  assign abs_b   = b[OPW-1] ? -b : b;
  assign partial = (MAG+DIG)'(mag_a) * (MAG+DIG)'(mag_b[DIG-1:0]);

  // Control: digit steps, then a fix step that applies the sign.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + MCW'(1);
        if (cnt == MCW'(NDIG - 1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: magnitudes, shifted partial products, signed result.
  always_ff @(posedge clk) begin
    if (start) begin
      mag_a <= abs_a[MAG-1:0];
      mag_b <= abs_b[MAG-1:0];
      neg   <= a[OPW-1] ^ b[OPW-1];
      acc   <= '0;
    end else if (busy) begin
      acc   <= acc + (PW'(partial) << (DIG * int'(cnt)));
      mag_b <= mag_b >> DIG;
    end else if (fix) begin
      prod <= neg ? -$signed(acc) : $signed(acc);
    end
  end

endmodule

`default_nettype wire

// ----- sv/wlf_div.sv -----
// Restoring divider, one quotient bit a cycle, rounding half away from zero
// and saturating to 32 bits. Depends on wlf_pkg.
`default_nettype none

module wlf_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [wlf_pkg::PW-1:0]    num,
  input  logic [wlf_pkg::DENW-1:0]         den,
  output logic                             done,
  output logic signed [wlf_pkg::QOUTW-1:0] quo
);
  import wlf_pkg::*;

  logic              busy;
  logic              fin;
  logic [DCW-1:0]    cnt;
  logic [PW-1:0]     mag;
  logic [DENW-1:0]   rem;
  logic [QW-1:0]     q;
  logic              ovf;
  logic              neg;
  logic [DENW:0]     rr;
  logic              ge;
  logic [DENW:0]     rr_sub;
  logic              rnd;
  logic [QW:0]       qr;
  logic [QW:0]       lim;
  logic              sat;
  logic [QOUTW-1:0]  mv;

  // One long-division step.
  assign rr     = {rem, mag[PW-1]};
  assign ge     = (rr >= {1'b0, den});
  assign rr_sub = rr - {1'b0, den};

  // Rounding and saturation of the finished quotient.
  assign rnd = ({rem, 1'b0} >= {1'b0, den});
  assign qr  = {1'b0, q} + (QW+1)'(rnd);
  assign lim = neg ? ((QW+1)'(1) << (QOUTW - 1)) : (((QW+1)'(1) << (QOUTW - 1)) - (QW+1)'(1));
  assign sat = ovf || (qr > lim);
  assign mv  = sat ? lim[QOUTW-1:0] : qr[QOUTW-1:0];

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCW'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - DCW'(1);
        if (cnt == DCW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[PW-1];
      mag <= num[PW-1] ? PW'(-num) : PW'(num);
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      rem <= ge ? rr_sub[DENW-1:0] : rr[DENW-1:0];
      q   <= {q[QW-2:0], ge};
      ovf <= ovf | q[QW-1];
      mag <= mag << 1;
    end else if (fin) begin
      quo <= neg ? -$signed(mv) : $signed(mv);
    end
  end

endmodule

`default_nettype wire

// ----- sv/wlf_back.sv -----
// Back end: product pipeline, weighted sums, x range and the fit sequencer
// that drives the shared multiplier and divider. Depends on wlf_pkg,
// wlf_mul and wlf_div.
`default_nettype none

module wlf_back (
  input  logic                      clk,
  input  logic                      rst,
  input  wlf_pkg::wlf_cfg_t         cfg,
  input  wlf_pkg::wlf_item_t        q_item,
  input  logic                      q_valid,
  output logic                      q_pop,
  output logic signed [31:0]        slope,
  output logic signed [31:0]        intercept,
  output logic signed [15:0]        x_min,
  output logic signed [15:0]        x_max,
  output logic                      fit_valid,
  output logic                      out_valid,
  input  logic                      out_ready
);
  import wlf_pkg::*;

  // Product order of the fit sequence.
  localparam logic [2:0] STEP_N_XX  = 3'd0;
  localparam logic [2:0] STEP_X_X   = 3'd1;
  localparam logic [2:0] STEP_N_XY  = 3'd2;
  localparam logic [2:0] STEP_X_Y   = 3'd3;
  localparam logic [2:0] STEP_Y_XX  = 3'd4;
  localparam logic [2:0] STEP_X_XY  = 3'd5;

  back_state_t state;
  back_state_t state_next;

  logic                   pop;
  logic                   load;
  logic                   mul_start;
  logic                   div_start;

  // Pipeline stages
  logic                   s1_valid;
  logic signed [XW-1:0]   s1_x;
  logic signed [XW-1:0]   s1_y;
  logic [WW-1:0]          s1_w;
  logic signed [WXW-1:0]  s1_wx;
  logic signed [WXW-1:0]  s1_wy;
  logic                   s2_valid;
  logic [WW-1:0]          s2_w;
  logic signed [WXW-1:0]  s2_wx;
  logic signed [WXW-1:0]  s2_wy;
  logic signed [WXXW-1:0] s2_wxx;
  logic signed [WXXW-1:0] s2_wxy;
  logic signed [WW:0]     w_s;

  // Run state
  logic [NW-1:0]          sum_weight;
  logic signed [SXW-1:0]  sum_wx;
  logic signed [SXXW-1:0] sum_wxx;
  logic signed [SXW-1:0]  sum_wy;
  logic signed [SXXW-1:0] sum_wxy;
  logic signed [XW-1:0]   range_low;
  logic signed [XW-1:0]   range_high;
  logic                   range_seen;
  logic                   run_profile;

  // Fit state
  logic [2:0]             step;
  logic signed [PW-1:0]   disc;
  logic signed [PW-1:0]   num_s;
  logic signed [PW-1:0]   num_i;
  logic                   div_sel;
  logic signed [QOUTW-1:0] slope_r;
  logic signed [QOUTW-1:0] intercept_r;
  logic                   disc_pos;

  logic signed [OPW-1:0]  mul_a;
  logic signed [OPW-1:0]  mul_b;
  logic                   mul_done;
  logic signed [PW-1:0]   mul_prod;
  logic signed [PW-1:0]   div_num;
  logic                   div_done;
  logic signed [QOUTW-1:0] div_quo;
  logic signed [XW-1:0]   lo_val;
  logic signed [XW-1:0]   hi_val;

  assign disc_pos = !disc[PW-1] && (disc != '0);
  assign w_s      = {1'b0, q_item.w};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_ACCUM: begin
        if (q_valid && q_item.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid && !s2_valid) begin
          state_next = ST_MUL_START;
        end
      end
      ST_MUL_START: begin
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          if (step != STEP_X_XY) begin
            state_next = ST_MUL_START;
          end else if (disc_pos) begin
            state_next = ST_DIV_START;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_DIV_START: begin
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = div_sel ? ST_OUT : ST_DIV_START;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    pop       = 1'b0;
    load      = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_ACCUM:     pop       = q_valid;
      ST_MUL_START: mul_start = 1'b1;
      ST_DIV_START: div_start = 1'b1;
      ST_OUT:       load      = !out_valid || out_ready;
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  assign q_pop = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  // Stage one: weight times x and y.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= pop && q_item.counted;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_x  <= q_item.x;
    s1_y  <= q_item.y;
    s1_w  <= q_item.w;
    s1_wx <= w_s * $signed(q_item.x);
    s1_wy <= w_s * $signed(q_item.y);
    // Stage two: second-order products.
    s2_w   <= s1_w;
    s2_wx  <= s1_wx;
    s2_wy  <= s1_wy;
    s2_wxx <= s1_wx * s1_x;
    s2_wxy <= s1_wx * s1_y;
  end

  // Stage three: weighted sums, wrapping at their widths; cleared after a fit.
  always_ff @(posedge clk) begin
    if (rst || load) begin
      sum_weight <= '0;
      sum_wx     <= '0;
      sum_wxx    <= '0;
      sum_wy     <= '0;
      sum_wxy    <= '0;
    end else if (s2_valid) begin
      sum_weight <= sum_weight + NW'(s2_w);
      sum_wx     <= sum_wx + SXW'(s2_wx);
      sum_wxx    <= sum_wxx + SXXW'(s2_wxx);
      sum_wy     <= sum_wy + SXW'(s2_wy);
      sum_wxy    <= sum_wxy + SXXW'(s2_wxy);
    end
  end

  // Range of counted x.
  always_ff @(posedge clk) begin
    if (rst || load) begin
      range_seen <= 1'b0;
    end else if (pop && q_item.counted) begin
      range_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.counted) begin
      if (!range_seen || ($signed(q_item.x) < range_low)) begin
        range_low <= q_item.x;
      end
      if (!range_seen || ($signed(q_item.x) > range_high)) begin
        range_high <= q_item.x;
      end
    end
    if (pop && q_item.last) begin
      run_profile <= q_item.profile;
    end
  end

  // Multiplier operand selection.
  always_comb begin
    case (step)
      STEP_N_XX: begin
        mul_a = OPW'($signed({1'b0, sum_weight}));
        mul_b = OPW'(sum_wxx);
      end
      STEP_X_X: begin
        mul_a = OPW'(sum_wx);
        mul_b = OPW'(sum_wx);
      end
      STEP_N_XY: begin
        mul_a = OPW'($signed({1'b0, sum_weight}));
        mul_b = OPW'(sum_wxy);
      end
      STEP_X_Y: begin
        mul_a = OPW'(sum_wx);
        mul_b = OPW'(sum_wy);
      end
      STEP_Y_XX: begin
        mul_a = OPW'(sum_wy);
        mul_b = OPW'(sum_wxx);
      end
      STEP_X_XY: begin
        mul_a = OPW'(sum_wx);
        mul_b = OPW'(sum_wxy);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Discriminant and numerators, built from the product sequence.
  always_ff @(posedge clk) begin
    if (state == ST_DRAIN) begin
      step        <= STEP_N_XX;
      div_sel     <= 1'b0;
      slope_r     <= '0;
      intercept_r <= '0;
    end else if ((state == ST_MUL_WAIT) && mul_done) begin
      step <= step + 3'd1;
      case (step)
        STEP_N_XX: disc  <= mul_prod;
        STEP_X_X:  disc  <= disc - mul_prod;
        STEP_N_XY: num_s <= mul_prod;
        STEP_X_Y:  num_s <= num_s - mul_prod;
        STEP_Y_XX: num_i <= mul_prod;
        STEP_X_XY: num_i <= num_i - mul_prod;
        default: begin
          disc <= disc;
        end
      endcase
    end else if ((state == ST_DIV_WAIT) && div_done) begin
      div_sel <= 1'b1;
      if (div_sel) begin
        intercept_r <= div_quo;
      end else begin
        slope_r <= div_quo;
      end
    end
  end

  assign div_num = div_sel ? (num_i <<< 8) : (num_s <<< 16);

  wlf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  wlf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (disc[DENW-1:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Reported x range follows the mode of the last item.
  always_comb begin
    lo_val = range_low;
    hi_val = range_high;
    if (run_profile) begin
      if (!range_seen) begin
        lo_val = cfg.x_upper_bound;
        hi_val = cfg.x_upper_bound;
      end else if (cfg.x_upper_bound < range_low) begin
        lo_val = cfg.x_upper_bound;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slope     <= slope_r;
      intercept <= intercept_r;
      x_min     <= lo_val;
      x_max     <= hi_val;
      fit_valid <= disc_pos;
    end
  end

  // No item leaves the queue while a fit is in progress.
  a_no_pop_in_fit: assert property (@(posedge clk) disable iff (rst)
    (state != ST_ACCUM) |-> !q_pop)
    else $error("item popped during fit");

  // The sums are complete before the first product starts.
  a_drained: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> (!s1_valid && !s2_valid))
    else $error("fit started with items in flight");

  // A result is only written over one that has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_valid || out_ready))
    else $error("result overwritten");

  // A rejected fit reports zero slope and intercept.
  a_zero_on_invalid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !fit_valid) |-> (slope == '0 && intercept == '0))
    else $error("nonzero fit with invalid flag");

endmodule

`default_nettype wire

// ----- sv/weighted_line_fit.sv -----
// Weighted straight-line fit: a bin is accepted every cycle while the 4-entry queue has room.
// Non-last bins: each passes from the queue through stages one and two into the sums.
// Last bin: the pipeline drains, then 6 products run on the shared multiplier and, if the
// discriminant is positive, 2 divisions run on the shared bit-serial divider.
// Synchronous reset clears the queue, sums and out_valid; profile_mode resets to 1 and
// x_upper_bound to 32767.
// Top level: config registers, front end and back end. Depends on wlf_pkg,
// wlf_front and wlf_back.
`default_nettype none

module weighted_line_fit (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [15:0] x_value,
  input  logic signed [15:0] y_mean,
  input  logic [15:0]        weight,
  input  logic               last,
  input  logic               in_valid,
  output logic               in_ready,
  output logic signed [31:0] slope,
  output logic signed [31:0] intercept,
  output logic signed [15:0] x_min,
  output logic signed [15:0] x_max,
  output logic               fit_valid,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import wlf_pkg::*;

  wlf_cfg_t  cfg;
  wlf_item_t q_item;
  logic      q_valid;
  logic      q_pop;
  logic      cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.profile_mode  <= 1'b1;
      cfg.x_upper_bound <= 16'sh7FFF;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_PROFILE_MODE: cfg.profile_mode  <= pwdata[0];
        REG_X_UPPER:      cfg.x_upper_bound <= pwdata[15:0];
        default: begin
          cfg.profile_mode <= cfg.profile_mode;
        end
      endcase
    end
  end

  // Register read.
  always_comb begin
    case (paddr[2])
      REG_PROFILE_MODE: prdata = {31'b0, cfg.profile_mode};
      REG_X_UPPER:      prdata = {16'b0, cfg.x_upper_bound};
      default:          prdata = '0;
    endcase
  end

  wlf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .x_value  (x_value),
    .y_mean   (y_mean),
    .weight   (weight),
    .last     (last),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop)
  );

  wlf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .slope     (slope),
    .intercept (intercept),
    .x_min     (x_min),
    .x_max     (x_max),
    .fit_valid (fit_valid),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

`default_nettype wire
